// ===== hw/rtl/tgw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgw_pkg: shared definitions for the tile grid wipe transition unit
// Action and direction codes, fade mode, controller/datapath interface types.
// ----------------------------------------------------------------------------
package tgw_pkg;

    localparam int GRID_W_DEF = 20;
    localparam int GRID_H_DEF = 15;
    localparam int FRAME_W    = 4;
    localparam int FRAME_MAX  = 15;
    localparam int TAIL_STEPS = 16;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_FADE_OUT = 3'd1;
    localparam logic [2:0] ACT_FADE_IN  = 3'd2;
    localparam logic [2:0] ACT_SET_MASK = 3'd3;
    localparam logic [2:0] ACT_CLEAR    = 3'd4;

    localparam logic [2:0] DIR_LEFT   = 3'd0;
    localparam logic [2:0] DIR_UP     = 3'd1;
    localparam logic [2:0] DIR_RIGHT  = 3'd2;
    localparam logic [2:0] DIR_DOWN   = 3'd3;
    localparam logic [2:0] DIR_CENTER = 3'd4;

    typedef enum logic [1:0] {
        FADE_IDLE = 2'd0,
        FADE_IN   = 2'd1,
        FADE_OUT  = 2'd2
    } fade_mode_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // latch the input transaction
        logic apply;        // apply the latched action to the fade flags
        logic sweep_start;  // begin a pass over all tiles
        logic sweep_fill;   // pass writes a constant word instead of stepping
        logic fill_full;    // fill value is FRAME_MAX rather than zero
        logic tick_end;     // advance the step count after a tick pass
        logic respond;      // register the result and raise done
    } tgw_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] action;
        logic       fade_on;
        logic       sweep_done;
    } tgw_status_t;

endpackage

// ===== hw/rtl/tgw_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgw_ctrl: transaction sequencer
// Decodes each accepted transaction and steps the datapath through the
// tile pass where the action needs one, the tile readout and the result strobe.
// ----------------------------------------------------------------------------
module tgw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  tgw_pkg::tgw_status_t  status,
    output tgw_pkg::tgw_cmd_t     cmd,
    output logic                  busy
);
    import tgw_pkg::*;

    typedef enum logic [2:0] {
        S_BOOT,
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_TICK,
        S_READ,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_BOOT:
            begin
                // clear every tile after reset
                cmd.sweep_start = 1'b1;
                cmd.sweep_fill  = 1'b1;
                state_next      = S_CLEAR;
            end
            S_CLEAR:
            begin
                if (status.sweep_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.apply = 1'b1;
                unique case (status.action)
                    ACT_TICK:
                    begin
                        if (status.fade_on)
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = S_TICK;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    ACT_FADE_OUT:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_fill  = 1'b1;
                        state_next      = S_FILL;
                    end
                    ACT_FADE_IN:
                    begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_fill  = 1'b1;
                        cmd.fill_full   = 1'b1;
                        state_next      = S_FILL;
                    end
                    default:
                    begin
                        state_next = S_READ;
                    end
                endcase
            end
            S_FILL:
            begin
                if (status.sweep_done)
                begin
                    state_next = S_READ;
                end
            end
            S_TICK:
            begin
                if (status.sweep_done)
                begin
                    cmd.tick_end = 1'b1;
                    state_next   = S_READ;
                end
            end
            S_READ:
            begin
                // tile memory read of the addressed tile is in flight
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.respond = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_BOOT;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hw/rtl/tgw_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgw_datapath: tile memory, tile sweep pipeline and fade state
// One tile per cycle is read, stepped (or filled) and written back.
// ----------------------------------------------------------------------------
module tgw_datapath #(
    parameter int GRID_W = tgw_pkg::GRID_W_DEF,
    parameter int GRID_H = tgw_pkg::GRID_H_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tgw_pkg::tgw_cmd_t     cmd,
    output tgw_pkg::tgw_status_t  status,
    input  logic [2:0]            action,
    input  logic [2:0]            direction,
    input  logic [4:0]            tile_col,
    input  logic [3:0]            tile_row,
    output logic [3:0]            frame,
    output logic                  mask_on,
    output logic                  active,
    output logic                  done
);
    import tgw_pkg::*;

    localparam int NTILES = GRID_W * GRID_H;
    localparam int IDX_W  = $clog2(NTILES);
    localparam int XW     = $clog2(GRID_W);
    localparam int YW     = $clog2(GRID_H);
    localparam int LIMIT  = ((GRID_W > GRID_H) ? GRID_W : GRID_H) + TAIL_STEPS;
    localparam int CNT_W  = $clog2(LIMIT + 2);
    localparam int SUM_W  = $clog2(GRID_W + GRID_H + LIMIT + 2) + 1;
    localparam int LIN_W  = $clog2(16 * GRID_W + 32);
    localparam int HALF_W = GRID_W / 2;
    localparam int HALF_H = GRID_H / 2;
    localparam int WORD_W = FRAME_W + 1;

    // latched transaction
    logic [2:0]         act_reg;
    logic [2:0]         dir_in_reg;
    logic [4:0]         col_reg;
    logic [3:0]         row_reg;

    // fade state
    fade_mode_t         mode_reg;
    fade_mode_t         mode_next;
    logic [CNT_W-1:0]   step_reg;
    logic [CNT_W-1:0]   step_next;
    logic [CNT_W-1:0]   step_inc;
    logic [2:0]         dir_reg;
    logic [2:0]         dir_next;
    logic               mask_reg;
    logic               mask_next;

    // sweep issue stage
    logic               run_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [XW-1:0]      x_reg;
    logic [YW-1:0]      y_reg;
    logic               op_fill_reg;
    logic               fill_full_reg;

    // sweep write-back stage
    logic               s1_valid_reg;
    logic               s1_last_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [XW-1:0]      s1_x_reg;
    logic [YW-1:0]      s1_y_reg;

    // tile memory: {started, frame}
    logic [WORD_W-1:0]  tile_mem [NTILES];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [WORD_W-1:0]  wr_word;

    logic [LIN_W-1:0]   tile_lin;
    logic               in_range;

    logic [3:0]         frame_reg;
    logic               done_reg;

    logic [XW-1:0]      dx;
    logic [YW-1:0]      dy;
    logic [SUM_W-1:0]   pos;
    logic [SUM_W-1:0]   xs;
    logic [SUM_W-1:0]   ys;
    logic [SUM_W-1:0]   ring;
    logic               front;
    logic               fade_in;
    logic               rd_started;
    logic [3:0]         rd_frame;
    logic               started_new;
    logic [3:0]         frame_new;

    // ---------------------------------------------------------------- input latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            act_reg    <= action;
            dir_in_reg <= direction;
            col_reg    <= tile_col;
            row_reg    <= tile_row;
        end
    end

    // ---------------------------------------------------------------- fade state
    always_comb
    begin
        mode_next = mode_reg;
        step_next = step_reg;
        dir_next  = dir_reg;
        mask_next = mask_reg;
        step_inc  = step_reg + 1'b1;
        if (cmd.apply)
        begin
            case (act_reg)
                ACT_TICK:
                begin
                    if (mode_reg == FADE_IN)
                    begin
                        mask_next = 1'b0;
                    end
                end
                ACT_FADE_OUT:
                begin
                    mode_next = FADE_OUT;
                    step_next = '0;
                    dir_next  = dir_in_reg;
                    mask_next = 1'b0;
                end
                ACT_FADE_IN:
                begin
                    mode_next = FADE_IN;
                    step_next = '0;
                    dir_next  = dir_in_reg;
                    mask_next = 1'b1;
                end
                ACT_SET_MASK:
                begin
                    mask_next = 1'b1;
                end
                ACT_CLEAR:
                begin
                    mask_next = 1'b0;
                    mode_next = FADE_IDLE;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd.tick_end)
        begin
            step_next = step_inc;
            if (step_inc > CNT_W'(LIMIT))
            begin
                if (mode_reg == FADE_OUT)
                begin
                    mask_next = 1'b1;
                end
                mode_next = FADE_IDLE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= FADE_IDLE;
            step_reg <= '0;
            dir_reg  <= '0;
            mask_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            step_reg <= step_next;
            dir_reg  <= dir_next;
            mask_reg <= mask_next;
        end
    end

    // ---------------------------------------------------------------- sweep issue
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            idx_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            op_fill_reg   <= 1'b0;
            fill_full_reg <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s1_last_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= run_reg;
            s1_last_reg  <= run_reg && (idx_reg == IDX_W'(NTILES - 1));
            if (cmd.sweep_start)
            begin
                run_reg       <= 1'b1;
                idx_reg       <= '0;
                x_reg         <= '0;
                y_reg         <= '0;
                op_fill_reg   <= cmd.sweep_fill;
                fill_full_reg <= cmd.fill_full;
            end
            else if (run_reg)
            begin
                idx_reg <= idx_reg + 1'b1;
                if (x_reg == XW'(GRID_W - 1))
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x_reg + 1'b1;
                end
                if (idx_reg == IDX_W'(NTILES - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg <= idx_reg;
        s1_x_reg   <= x_reg;
        s1_y_reg   <= y_reg;
    end

    // ---------------------------------------------------------------- wavefront test
    always_comb
    begin
        dx   = (s1_x_reg < XW'(HALF_W)) ? s1_x_reg : XW'(GRID_W - 1) - s1_x_reg;
        dy   = (s1_y_reg < YW'(HALF_H)) ? s1_y_reg : YW'(GRID_H - 1) - s1_y_reg;
        pos  = SUM_W'(step_reg);
        xs   = SUM_W'(s1_x_reg);
        ys   = SUM_W'(s1_y_reg);
        ring = SUM_W'(dx) + SUM_W'(dy);
        fade_in = (mode_reg == FADE_IN);
        unique case (dir_reg)
            DIR_LEFT:   front = (xs + pos == SUM_W'(GRID_W - 1));
            DIR_RIGHT:  front = (xs == pos);
            DIR_UP:     front = (ys + pos == SUM_W'(GRID_H - 1));
            DIR_DOWN:   front = (ys == pos);
            // fade-in runs the diamond from the centre outward
            DIR_CENTER: front = fade_in ? (ring + pos == SUM_W'(GRID_W - 1))
                                        : (ring == pos);
            default:    front = 1'b0;
        endcase
    end

    // ---------------------------------------------------------------- tile update
    always_comb
    begin
        rd_started  = rd_data_reg[WORD_W-1];
        rd_frame    = rd_data_reg[FRAME_W-1:0];
        started_new = rd_started | front;
        frame_new   = rd_frame;
        if (started_new)
        begin
            if (fade_in)
            begin
                if (rd_frame != 4'd0)
                begin
                    frame_new = rd_frame - 4'd1;
                end
            end
            else if (rd_frame != 4'(FRAME_MAX))
            begin
                frame_new = rd_frame + 4'd1;
            end
        end
        if (op_fill_reg)
        begin
            wr_word = {1'b0, (fill_full_reg ? 4'(FRAME_MAX) : 4'd0)};
        end
        else
        begin
            wr_word = {started_new, frame_new};
        end
    end

    assign tile_lin = LIN_W'(row_reg) * LIN_W'(GRID_W) + LIN_W'(col_reg);
    assign in_range = ({3'b000, col_reg} < 8'(GRID_W)) && ({4'b0000, row_reg} < 8'(GRID_H));
    assign rd_addr  = run_reg ? idx_reg : IDX_W'(tile_lin);

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            tile_mem[s1_idx_reg] <= wr_word;
        end
        rd_data_reg <= tile_mem[rd_addr];
    end

    // ---------------------------------------------------------------- result
    always_ff @(posedge clk)
    begin
        if (cmd.respond)
        begin
            frame_reg <= in_range ? rd_data_reg[FRAME_W-1:0] : 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.respond;
        end
    end

    assign frame   = frame_reg;
    assign mask_on = mask_reg;
    assign active  = (mode_reg != FADE_IDLE);
    assign done    = done_reg;

    assign status.action     = act_reg;
    assign status.fade_on    = (mode_reg != FADE_IDLE);
    assign status.sweep_done = s1_valid_reg && s1_last_reg;

    // ---------------------------------------------------------------- checks
    a_wr_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ({1'b0, s1_idx_reg} < (IDX_W + 1)'(NTILES)))
        else $error("tile write beyond grid");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= CNT_W'(LIMIT + 1))
        else $error("step count ran past fade end");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_sweep_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.sweep_start |-> (!run_reg && !s1_valid_reg))
        else $error("tile pass restarted while one is running");

    a_tick_needs_fade: assert property (@(posedge clk) disable iff (!rst_n)
        (run_reg && !op_fill_reg) |-> (mode_reg != FADE_IDLE))
        else $error("tick pass with no fade running");

endmodule

// ===== hw/rtl/tile_grid_wipe_transition_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_grid_wipe_transition_unit: screen wipe over a grid of tiles
// Tick during a fade and both fade starts pass every tile through the tile
// memory, one tile per cycle, between accept and done; other actions and idle
// ticks do not. One transaction at a time. After reset the tile memory is
// cleared with busy high. done pulses one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
module tile_grid_wipe_transition_unit #(
    parameter int GRID_W = tgw_pkg::GRID_W_DEF,
    parameter int GRID_H = tgw_pkg::GRID_H_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  action,
    input  logic [2:0]  direction,
    input  logic [4:0]  tile_col,
    input  logic [3:0]  tile_row,
    output logic        done,
    output logic [3:0]  frame,
    output logic        mask_on,
    output logic        active
);
    import tgw_pkg::*;

    tgw_cmd_t    cmd;
    tgw_status_t status;

    tgw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    tgw_datapath #(
        .GRID_W (GRID_W),
        .GRID_H (GRID_H)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .action    (action),
        .direction (direction),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .frame     (frame),
        .mask_on   (mask_on),
        .active    (active),
        .done      (done)
    );

endmodule

// ===== dv/tile_grid_wipe_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_grid_wipe_checker: predictor and scoreboard for the tile wipe unit
// Watches accepted transactions, steps its own copy of the tile grid and fade
// state, queues the expected report and compares each done pulse against it.
// ----------------------------------------------------------------------------
module tile_grid_wipe_checker #(
    parameter int GRID_W = tgw_pkg::GRID_W_DEF,
    parameter int GRID_H = tgw_pkg::GRID_H_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [2:0] action,
    input  logic [2:0] direction,
    input  logic [4:0] tile_col,
    input  logic [3:0] tile_row,
    input  logic       done,
    input  logic [3:0] frame,
    input  logic       mask_on,
    input  logic       active,
    output int         error_count,
    output int         outstanding,
    output int         reports_checked,
    output int         fades_finished
);
    import tgw_pkg::*;

    typedef struct packed {
        logic [3:0] frame;
        logic       mask_on;
        logic       active;
    } tile_report_t;

    localparam int END_STEP = ((GRID_W > GRID_H) ? GRID_W : GRID_H) + TAIL_STEPS;

    logic [3:0]   grid_frame   [GRID_H][GRID_W];
    logic         grid_started [GRID_H][GRID_W];
    int           steps_q;
    fade_mode_t   mode_q;
    logic [2:0]   dir_q;
    logic         mask_q;
    tile_report_t reports_due [$];

    initial
    begin
        error_count     = 0;
        outstanding     = 0;
        reports_checked = 0;
        fades_finished  = 0;
    end

    function automatic void begin_fade(input fade_mode_t m, input logic [2:0] d,
                                       input logic [3:0] fill, input logic msk);
        mode_q  = m;
        steps_q = 0;
        dir_q   = d;
        mask_q  = msk;
        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
            begin
                grid_frame[y][x]   = fill;
                grid_started[y][x] = 1'b0;
            end
    endfunction

    function automatic bit on_wavefront(input int x, input int y, input int pos,
                                        input bit fade_in);
        int dx;
        int dy;
        int target;
        case (dir_q)
            DIR_LEFT:   return x == (GRID_W - 1) - pos;
            DIR_RIGHT:  return x == pos;
            DIR_UP:     return y == (GRID_H - 1) - pos;
            DIR_DOWN:   return y == pos;
            DIR_CENTER:
            begin
                dx     = (x < GRID_W / 2) ? x : (GRID_W - 1) - x;
                dy     = (y < GRID_H / 2) ? y : (GRID_H - 1) - y;
                target = fade_in ? (GRID_W - 1) - pos : pos;
                return dx + dy == target;
            end
            default:    return 1'b0;
        endcase
    endfunction

    function automatic void advance_wipe();
        bit fade_in;
        int pos;
        if (mode_q == FADE_IDLE)
            return;
        fade_in = (mode_q == FADE_IN);
        pos     = steps_q;
        if (fade_in)
            mask_q = 1'b0;
        for (int y = 0; y < GRID_H; y++)
            for (int x = 0; x < GRID_W; x++)
            begin
                if (on_wavefront(x, y, pos, fade_in))
                    grid_started[y][x] = 1'b1;
                if (grid_started[y][x])
                begin
                    if (fade_in && grid_frame[y][x] != 4'd0)
                        grid_frame[y][x] = grid_frame[y][x] - 4'd1;
                    else if (!fade_in && grid_frame[y][x] != 4'(FRAME_MAX))
                        grid_frame[y][x] = grid_frame[y][x] + 4'd1;
                end
            end
        steps_q++;
        if (steps_q > END_STEP)
        begin
            if (!fade_in)
                mask_q = 1'b1;
            mode_q = FADE_IDLE;
            fades_finished++;
        end
    endfunction

    function automatic tile_report_t predict_report(input logic [2:0] act,
                                                    input logic [2:0] d,
                                                    input logic [4:0] col,
                                                    input logic [3:0] row);
        tile_report_t rep;
        case (act)
            ACT_TICK:     advance_wipe();
            ACT_FADE_OUT: begin_fade(FADE_OUT, d, 4'd0, 1'b0);
            ACT_FADE_IN:  begin_fade(FADE_IN, d, 4'(FRAME_MAX), 1'b1);
            ACT_SET_MASK: mask_q = 1'b1;
            ACT_CLEAR:
            begin
                mask_q = 1'b0;
                mode_q = FADE_IDLE;
            end
            default: ;
        endcase
        if (int'(col) < GRID_W && int'(row) < GRID_H)
            rep.frame = grid_frame[row][col];
        else
            rep.frame = 4'd0;
        rep.mask_on = mask_q;
        rep.active  = (mode_q != FADE_IDLE);
        return rep;
    endfunction

    always @(posedge clk)
    begin
        tile_report_t want;
        if (!rst_n)
        begin
            begin_fade(FADE_IDLE, DIR_LEFT, 4'd0, 1'b0);
            reports_due.delete();
        end
        else
        begin
            // compare first: a done and a new accept may share one edge
            if (done)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("report with no transaction outstanding");
                    error_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    reports_checked++;
                    if (frame !== want.frame)
                    begin
                        $error("frame mismatch: expected %0d, got %0d", want.frame, frame);
                        error_count++;
                    end
                    if (mask_on !== want.mask_on)
                    begin
                        $error("mask_on mismatch: expected %0d, got %0d",
                               want.mask_on, mask_on);
                        error_count++;
                    end
                    if (active !== want.active)
                    begin
                        $error("active mismatch: expected %0d, got %0d", want.active, active);
                        error_count++;
                    end
                end
            end
            if (start && !busy)
                reports_due.push_back(predict_report(action, direction, tile_col, tile_row));
        end
        outstanding <= reports_due.size();
    end

endmodule

// ===== dv/tb_tile_grid_wipe_transition_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_grid_wipe_transition_unit: testbench for the tile wipe unit
// Directed corner cases, then random fade sequences with ticks and noise
// transactions, random gaps on the command side; checking in a separate module.
// ----------------------------------------------------------------------------
module tb_tile_grid_wipe_transition_unit;
    import tgw_pkg::*;

    localparam int RANDOM_ITEMS = 500;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic [2:0] action    = ACT_TICK;
    logic [2:0] direction = DIR_LEFT;
    logic [4:0] tile_col  = '0;
    logic [3:0] tile_row  = '0;
    logic       busy;
    logic       done;
    logic [3:0] frame;
    logic       mask_on;
    logic       active;

    int error_count;
    int outstanding;
    int reports_checked;
    int fades_finished;
    int sent;
    bit no_idle;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    tile_grid_wipe_transition_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .direction (direction),
        .tile_col  (tile_col),
        .tile_row  (tile_row),
        .done      (done),
        .frame     (frame),
        .mask_on   (mask_on),
        .active    (active)
    );

    tile_grid_wipe_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .direction       (direction),
        .tile_col        (tile_col),
        .tile_row        (tile_row),
        .done            (done),
        .frame           (frame),
        .mask_on         (mask_on),
        .active          (active),
        .error_count     (error_count),
        .outstanding     (outstanding),
        .reports_checked (reports_checked),
        .fades_finished  (fades_finished)
    );

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(0, 2);
        if (r < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // called right after a rising edge; returns at the edge that accepts
    task automatic issue(input logic [2:0] act, input logic [2:0] d,
                         input logic [4:0] col, input logic [3:0] row);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        direction <= d;
        tile_col  <= col;
        tile_row  <= row;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        sent++;
    endtask

    task automatic issue_random_tile(input logic [2:0] act, input logic [2:0] d);
        if ($urandom_range(0, 99) < 85)
            issue(act, d, 5'($urandom_range(0, 19)), 4'($urandom_range(0, 14)));
        else
            issue(act, d, 5'($urandom), 4'($urandom));
    endtask

    initial
    begin
        int run_len;
        logic [2:0] d;
        sent    = 0;
        no_idle = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, mask controls, unused actions, off-grid address
        issue(ACT_TICK, DIR_LEFT, 5'd0, 4'd0);
        issue(ACT_SET_MASK, DIR_CENTER, 5'd19, 4'd14);
        issue(ACT_CLEAR, 3'd7, 5'd31, 4'd15);
        issue(3'd5, DIR_UP, 5'd1, 4'd1);
        issue(3'd6, DIR_UP, 5'd20, 4'd3);
        issue(3'd7, DIR_UP, 5'd3, 4'd14);
        // fade-out from the right edge
        issue(ACT_FADE_OUT, DIR_LEFT, 5'd19, 4'd0);
        issue(ACT_TICK, DIR_LEFT, 5'd19, 4'd0);
        issue(ACT_TICK, DIR_DOWN, 5'd18, 4'd5);
        issue(ACT_TICK, DIR_LEFT, 5'd20, 4'd3);
        // fade-in from the centre
        issue(ACT_FADE_IN, DIR_CENTER, 5'd9, 4'd7);
        issue(ACT_TICK, DIR_CENTER, 5'd0, 4'd0);
        issue(ACT_TICK, DIR_CENTER, 5'd10, 4'd7);
        issue(ACT_TICK, DIR_CENTER, 5'd9, 4'd7);
        // unused direction: count runs, nothing starts
        issue(ACT_FADE_OUT, 3'd7, 5'd4, 4'd4);
        issue(ACT_TICK, 3'd7, 5'd4, 4'd4);
        issue(ACT_TICK, 3'd5, 5'd5, 4'd5);
        // mask and clear in the middle of a fade-in
        issue(ACT_FADE_IN, DIR_UP, 5'd0, 4'd14);
        issue(ACT_TICK, DIR_UP, 5'd0, 4'd14);
        issue(ACT_SET_MASK, DIR_UP, 5'd0, 4'd14);
        issue(ACT_CLEAR, DIR_UP, 5'd0, 4'd13);
        issue(ACT_TICK, DIR_UP, 5'd0, 4'd14);

        // random fade sequences with noise mixed in
        while (sent < RANDOM_ITEMS + 22)
        begin
            if ($urandom_range(0, 39) == 0)
                no_idle = !no_idle;
            if ($urandom_range(0, 99) < 80)
            begin
                d = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                 : 3'($urandom_range(5, 7));
                issue_random_tile($urandom_range(0, 1) ? ACT_FADE_IN : ACT_FADE_OUT, d);
                run_len = $urandom_range(30, 42);
                repeat (run_len)
                begin
                    if ($urandom_range(0, 99) < 5)
                        issue_random_tile(3'($urandom_range(3, 7)), 3'($urandom));
                    else
                        issue_random_tile(ACT_TICK, 3'($urandom));
                end
            end
            else
                issue_random_tile(3'($urandom_range(0, 7)), 3'($urandom));
        end
        start <= 1'b0;

        // let the last accept land in the scoreboard count
        @(posedge clk);
        wait (outstanding == 0);
        repeat (8) @(posedge clk);
        $display("Sent %0d transactions, %0d reports checked, %0d fades ran to completion.",
                 sent, reports_checked, fades_finished);
        if (error_count == 0 && outstanding == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d reports outstanding", outstanding);
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== tile_grid_wipe_transition_unit.f =====
hw/rtl/tgw_pkg.sv
hw/rtl/tgw_ctrl.sv
hw/rtl/tgw_datapath.sv
hw/rtl/tile_grid_wipe_transition_unit.sv
dv/tile_grid_wipe_checker.sv
dv/tb_tile_grid_wipe_transition_unit.sv
